>>> sv/mavg_alarm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mavg_alarm_pkg
// Shared types and constants of the moving-average alarm block.
// ----------------------------------------------------------------------------
package mavg_alarm_pkg;

  localparam int unsigned WINDOW     = 8;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned SLOT_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  // sum of WINDOW signed samples, exact
  localparam int unsigned TOTAL_W    = SAMPLE_W + $clog2(WINDOW);
  // floor(log2(WINDOW))
  localparam int unsigned MEAN_SHIFT = $clog2(WINDOW + 1) - 1;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = SAMPLE_W;

  localparam logic [CFG_IDX_W-1:0] CFG_WARNING_LIMIT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL_LIMIT = CFG_IDX_W'(1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [TOTAL_W-1:0]  total_t;
  typedef logic [SLOT_W-1:0]          slot_t;

  typedef enum logic {
    CMD_SAMPLE  = 1'b0,
    CMD_PRELOAD = 1'b1
  } command_e;

  typedef enum logic [1:0] {
    SEV_NORMAL   = 2'd0,
    SEV_WARNING  = 2'd1,
    SEV_CRITICAL = 2'd2
  } severity_e;

endpackage
`default_nettype wire

>>> sv/mavg_alarm_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mavg_alarm_in_if
// Command channel: sample or preload command with its value.
// ----------------------------------------------------------------------------
interface mavg_alarm_in_if import mavg_alarm_pkg::*;;

  logic     valid;
  logic     ready;
  command_e command;
  sample_t  sample;

  modport source (output valid, output command, output sample, input ready);
  modport sink   (input valid, input command, input sample, output ready);

endinterface
`default_nettype wire

>>> sv/mavg_alarm_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mavg_alarm_out_if
// Result channel: window mean and alarm severity.
// ----------------------------------------------------------------------------
interface mavg_alarm_out_if import mavg_alarm_pkg::*;;

  logic      valid;
  logic      ready;
  sample_t   mean_level;
  severity_e severity;

  modport source (output valid, output mean_level, output severity, input ready);
  modport sink   (input valid, input mean_level, input severity, output ready);

endinterface
`default_nettype wire

>>> sv/mavg_alarm_window.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mavg_alarm_window
// Ring window of samples with running total; gives the mean after an update.
// ----------------------------------------------------------------------------
module mavg_alarm_window import mavg_alarm_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     update_i,
  input  wire command_e command_i,
  input  wire sample_t  sample_i,
  output sample_t       mean_o
);

  sample_t win_q [WINDOW];
  slot_t   slot_q, slot_d;
  total_t  total_q, total_d;
  total_t  sample_ext, oldest_ext, preload_total, shifted;

  always_comb begin
    sample_ext    = total_t'(sample_i);
    oldest_ext    = total_t'(win_q[slot_q]);
    preload_total = sample_ext * signed'(TOTAL_W'(WINDOW));
    if (command_i == CMD_PRELOAD) begin
      total_d = preload_total;
      slot_d  = '0;
    end else begin
      total_d = total_q + sample_ext - oldest_ext;
      slot_d  = (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + SLOT_W'(1);
    end
    shifted = total_d >>> MEAN_SHIFT;
    // preload reports the value itself, also for a window that is no power of two
    mean_o  = (command_i == CMD_PRELOAD) ? sample_i : shifted[SAMPLE_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      total_q <= '0;
      for (int i = 0; i < WINDOW; i++) win_q[i] <= '0;
    end else if (update_i) begin
      slot_q  <= slot_d;
      total_q <= total_d;
      if (command_i == CMD_PRELOAD) begin
        for (int i = 0; i < WINDOW; i++) win_q[i] <= sample_i;
      end else begin
        win_q[slot_q] <= sample_i;
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/mavg_alarm_grade.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mavg_alarm_grade
// Grades the mean against the warning and critical limits.
// ----------------------------------------------------------------------------
module mavg_alarm_grade import mavg_alarm_pkg::*; (
  input  wire sample_t  mean_i,
  input  wire sample_t  warning_i,
  input  wire sample_t  critical_i,
  input  wire command_e command_i,
  output severity_e     severity_o
);

  logic high_going, hit_crit, hit_warn;

  always_comb begin
    // equal limits fall to the low-going direction
    high_going = warning_i < critical_i;
    hit_crit   = high_going ? (mean_i >= critical_i) : (mean_i <= critical_i);
    hit_warn   = high_going ? (mean_i >= warning_i)  : (mean_i <= warning_i);
    if (command_i == CMD_PRELOAD) begin
      severity_o = SEV_NORMAL;
    end else if (hit_crit) begin
      severity_o = SEV_CRITICAL;
    end else if (hit_warn) begin
      severity_o = SEV_WARNING;
    end else begin
      severity_o = SEV_NORMAL;
    end
  end

endmodule
`default_nettype wire

>>> sv/moving_average_dual_threshold_alarm_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// moving_average_dual_threshold_alarm_top
// Moving-average filter over a sample window with a two-level alarm.
// ----------------------------------------------------------------------------
// Every command transaction gives one result in the next cycle: the window
// update, the shift to the mean and the two limit compares sit between the
// window registers and the result register, so one transaction is taken per
// cycle. A result that waits on a stalled output holds the command channel
// off until it is taken; output ready passes straight to input ready, so the
// next transaction goes in at the same edge that takes the waiting result. A
// sample command replaces the oldest window entry; a preload fills the whole
// window and reports the value with severity normal. Users write limits
// through the configuration port only while no transaction is in flight; the
// block does not enforce it. warning < critical: rising alarm, else falling.
module moving_average_dual_threshold_alarm_top import mavg_alarm_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  mavg_alarm_in_if.sink              in_chan_i,
  mavg_alarm_out_if.source           out_chan_o
);

  sample_t   warning_q, critical_q;
  logic      out_valid_q;
  sample_t   mean_q;
  severity_e sev_q;

  logic      accept;
  sample_t   mean_d;
  severity_e sev_d;

  assign in_chan_i.ready = !out_valid_q || out_chan_o.ready;
  assign accept          = in_chan_i.valid && in_chan_i.ready;

  mavg_alarm_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .update_i  (accept),
    .command_i (in_chan_i.command),
    .sample_i  (in_chan_i.sample),
    .mean_o    (mean_d)
  );

  mavg_alarm_grade u_grade (
    .mean_i     (mean_d),
    .warning_i  (warning_q),
    .critical_i (critical_q),
    .command_i  (in_chan_i.command),
    .severity_o (sev_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warning_q  <= '0;
      critical_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WARNING_LIMIT:  warning_q  <= sample_t'(cfg_wdata_i);
        CFG_CRITICAL_LIMIT: critical_q <= sample_t'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_chan_i.ready) begin
      out_valid_q <= in_chan_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mean_q <= mean_d;
      sev_q  <= sev_d;
    end
  end

  assign out_chan_o.valid      = out_valid_q;
  assign out_chan_o.mean_level = mean_q;
  assign out_chan_o.severity   = sev_q;

endmodule
`default_nettype wire

>>> test/tb_moving_average_dual_threshold_alarm_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_moving_average_dual_threshold_alarm_top
// Checks the windowed mean and the two-level alarm grade of every command
// against a cycle-free window model. Limits are changed between phases, both
// channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_moving_average_dual_threshold_alarm_top;
  import mavg_alarm_pkg::*;

  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned MAX_REPORTS = 200;

  typedef struct packed {
    command_e cmd;
    sample_t  value;
  } cmd_item_t;

  typedef struct packed {
    sample_t   mean;
    severity_e sev;
  } mean_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  mavg_alarm_in_if  in_chan ();
  mavg_alarm_out_if out_chan ();

  moving_average_dual_threshold_alarm_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_chan_i   (in_chan.sink),
    .out_chan_o  (out_chan.source)
  );

  cmd_item_t    cmd_queue [$];
  mean_result_t expected_means [$];
  int unsigned  mismatch_count = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  gap_left;
  int unsigned  stall_left;
  bit           steady_flow;

  // window model
  sample_t     window_copy [WINDOW] = '{default: '0};
  int unsigned next_slot = 0;
  total_t      window_total = '0;
  sample_t     warn_level;
  sample_t     crit_level;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string msg);
    if (mismatch_count < MAX_REPORTS) $display("%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic mean_result_t advance_window(cmd_item_t item);
    mean_result_t res;
    total_t       shifted;
    if (item.cmd == CMD_PRELOAD) begin
      window_total = '0;
      foreach (window_copy[i]) begin
        window_copy[i] = item.value;
        window_total   = window_total + total_t'(item.value);
      end
      next_slot = 0;
      res.mean  = item.value;
      res.sev   = SEV_NORMAL;
      return res;
    end
    window_total = window_total + total_t'(item.value) - total_t'(window_copy[next_slot]);
    window_copy[next_slot] = item.value;
    next_slot = (next_slot + 1 >= WINDOW) ? 0 : next_slot + 1;
    // arithmetic shift floors toward minus infinity
    shifted  = window_total >>> MEAN_SHIFT;
    res.mean = sample_t'(shifted);
    if (warn_level < crit_level) begin
      if (res.mean >= crit_level)      res.sev = SEV_CRITICAL;
      else if (res.mean >= warn_level) res.sev = SEV_WARNING;
      else                             res.sev = SEV_NORMAL;
    end else begin
      if (res.mean <= crit_level)      res.sev = SEV_CRITICAL;
      else if (res.mean <= warn_level) res.sev = SEV_WARNING;
      else                             res.sev = SEV_NORMAL;
    end
    return res;
  endfunction

  function automatic sample_t clamp_level(int v);
    if (v > 32767)  return sample_t'(32767);
    if (v < -32768) return sample_t'(-32768);
    return sample_t'(v);
  endfunction

  // mostly short runs, now and then a long one
  function automatic int unsigned idle_run();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  function automatic cmd_item_t random_command();
    cmd_item_t   item;
    int unsigned pick;
    int          base;
    pick = $urandom_range(0, 99);
    item.cmd = ($urandom_range(0, 99) < 8) ? CMD_PRELOAD : CMD_SAMPLE;
    if (pick < 10) begin
      item.value = $urandom_range(0, 1) ? sample_t'(32767) : sample_t'(-32768);
    end else if (pick < 60) begin
      // hover around a limit so the mean crosses it both ways
      base = $urandom_range(0, 1) ? int'(warn_level) : int'(crit_level);
      item.value = clamp_level(base + int'($urandom_range(0, 600)) - 300);
    end else begin
      item.value = sample_t'($urandom);
    end
    return item;
  endfunction

  task automatic push_cmd(command_e cmd, int value);
    cmd_item_t item;
    item.cmd   = cmd;
    item.value = clamp_level(value);
    cmd_queue.push_back(item);
  endtask

  task automatic write_limit(logic [CFG_IDX_W-1:0] idx, sample_t value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_WARNING_LIMIT) warn_level = value;
    else                          crit_level = value;
  endtask

  task automatic set_limits(int warn, int crit);
    write_limit(CFG_WARNING_LIMIT, clamp_level(warn));
    write_limit(CFG_CRITICAL_LIMIT, clamp_level(crit));
    @(negedge clk_i);
  endtask

  task automatic pick_limits();
    int w;
    int c;
    case ($urandom_range(0, 4))
      0: begin
        w = int'(sample_t'($urandom));
        c = int'(sample_t'($urandom));
      end
      1: begin
        w = int'($urandom_range(0, 8000)) - 4000;
        c = w + int'($urandom_range(1, 4000));
      end
      2: begin
        c = int'($urandom_range(0, 8000)) - 4000;
        w = c + int'($urandom_range(1, 4000));
      end
      3: begin
        w = int'($urandom_range(0, 8000)) - 4000;
        c = w;
      end
      default: begin
        w = $urandom_range(0, 1) ? 32767 : -32768;
        c = $urandom_range(0, 1) ? 32767 : -32768;
      end
    endcase
    set_limits(w, c);
  endtask

  // all commands sent, all results back, plus a short settle
  task automatic wait_idle();
    @(negedge clk_i);
    while (cmd_queue.size() != 0 || in_chan.valid || expected_means.size() != 0)
      @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  // command driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_chan.valid   <= 1'b0;
      in_chan.command <= CMD_SAMPLE;
      in_chan.sample  <= '0;
      gap_left        <= 0;
    end else if (!in_chan.valid || in_chan.ready) begin
      if (gap_left != 0) begin
        in_chan.valid <= 1'b0;
        gap_left      <= gap_left - 1;
      end else if (cmd_queue.size() != 0) begin
        in_chan.valid   <= 1'b1;
        in_chan.command <= cmd_queue[0].cmd;
        in_chan.sample  <= cmd_queue[0].value;
        cmd_queue.pop_front();
        gap_left <= (steady_flow || $urandom_range(0, 99) < 55) ? 0 : idle_run();
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // result backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_chan.ready <= 1'b0;
      stall_left     <= 0;
    end else if (stall_left != 0) begin
      out_chan.ready <= 1'b0;
      stall_left     <= stall_left - 1;
    end else if (!steady_flow && $urandom_range(0, 99) < 25) begin
      out_chan.ready <= 1'b0;
      stall_left     <= idle_run() - 1;
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  // monitor: check results first, then predict, so a same-edge transaction
  // pair never matches itself
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_chan.valid && out_chan.ready) begin : check_result
        mean_result_t oldest;
        if (expected_means.size() == 0) begin
          report_mismatch($sformatf("unexpected result mean=%0d severity=%0d",
                                    out_chan.mean_level, out_chan.severity));
        end else begin
          oldest = expected_means.pop_front();
          if (out_chan.mean_level !== oldest.mean)
            report_mismatch($sformatf("mean_level %0d, want %0d",
                                      out_chan.mean_level, oldest.mean));
          if (out_chan.severity !== oldest.sev)
            report_mismatch($sformatf("severity %0d, want %0d (mean %0d)",
                                      out_chan.severity, oldest.sev, oldest.mean));
        end
      end
      if (in_chan.valid && in_chan.ready) begin : predict_result
        cmd_item_t accepted;
        accepted.cmd   = in_chan.command;
        accepted.value = in_chan.sample;
        expected_means.push_back(advance_window(accepted));
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) || cfg_we_i)
        idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else
        idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned sent;
    int unsigned n;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_WARNING_LIMIT;
    cfg_wdata_i     = '0;
    steady_flow     = 1'b0;
    warn_level      = '0;
    crit_level      = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset limits are equal: low-going, a zero mean is critical
    push_cmd(CMD_SAMPLE, 0);
    push_cmd(CMD_SAMPLE, 32767);
    push_cmd(CMD_PRELOAD, 32767);
    push_cmd(CMD_SAMPLE, -32768);
    push_cmd(CMD_PRELOAD, -32768);
    push_cmd(CMD_SAMPLE, 32767);
    push_cmd(CMD_SAMPLE, -1);
    push_cmd(CMD_PRELOAD, 0);
    wait_idle();

    // high-going, preload at critical still reports normal
    set_limits(100, 1000);
    push_cmd(CMD_PRELOAD, 1000);
    push_cmd(CMD_SAMPLE, 1000);
    push_cmd(CMD_SAMPLE, -32768);
    push_cmd(CMD_SAMPLE, -7);
    push_cmd(CMD_PRELOAD, 99);
    push_cmd(CMD_SAMPLE, 107);
    wait_idle();

    set_limits(-32768, 32767);
    push_cmd(CMD_PRELOAD, 32767);
    push_cmd(CMD_SAMPLE, 32767);
    push_cmd(CMD_PRELOAD, -32768);
    push_cmd(CMD_SAMPLE, -32768);
    wait_idle();

    set_limits(32767, -32768);
    push_cmd(CMD_PRELOAD, -32768);
    push_cmd(CMD_SAMPLE, -32768);
    push_cmd(CMD_SAMPLE, 32767);
    push_cmd(CMD_PRELOAD, 32767);
    push_cmd(CMD_SAMPLE, 32767);
    wait_idle();

    sent = 0;
    while (sent < 500) begin
      pick_limits();
      steady_flow = ($urandom_range(0, 3) == 0);
      n = $urandom_range(40, 70);
      repeat (n) cmd_queue.push_back(random_command());
      sent += n;
      wait_idle();
    end

    steady_flow = 1'b0;
    repeat (5) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
